FILE: hw/rtl/bct_pkg.sv
// Shared definitions for the bitmap collision tester: sizes, derived widths,
// command and register codes, controller states and the control/status structs.
// No dependencies.
`default_nettype none

package bct_pkg;

  // Largest bitmap the block can hold.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  // Field and register widths.
  localparam int FIELD_W = 16;
  localparam int CFG_W   = 9;

  // Derived widths.
  localparam int XLW  = $clog2(MAX_WIDTH + 1);   // column index, may equal the width
  localparam int YW   = $clog2(MAX_HEIGHT);      // row address of the bitmap RAM
  localparam int CW   = FIELD_W + 2;             // signed coordinate arithmetic
  localparam int FRAC = 16;                      // fraction bits of the line walk
  localparam int PW   = CW + FRAC;               // signed fixed-point position
  localparam int NW   = $clog2(MAX_DIM + 1);     // line step count
  localparam int QW   = FRAC + 1;                // step quotient, at most one pixel
  localparam int DCW  = $clog2(QW);              // divider iteration count

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_POINT = 2'd1,
    CMD_RECT  = 2'd2,
    CMD_LINE  = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WR_WRITE,
    ST_RECT,
    ST_DIV,
    ST_WALK,
    ST_DRAIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clr_step;
    logic wr_read;
    logic wr_write;
    logic probe_pt;
    logic probe_rect;
    logic probe_line;
    logic div_init;
    logic div_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic clr_last;
    logic wr_ok;
    logic rect_oob;
    logic rect_empty;
    logic line_oob;
    logic line_zero;
    logic rect_last;
    logic div_last;
    logic walk_last;
    logic hit_detect;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bct_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle: a write, or a read whose data is registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bct_ctrl.sv
// Controller state machine of the bitmap collision tester.
// Depends on bct_pkg for states, command codes and the control/status structs.
`default_nettype none

module bct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bct_pkg::ctrl_stat_t stat_i,
  output bct_pkg::ctrl_cmd_t  cmd_o,
  output logic               done_o,
  output logic               hit_o
);

  bct_pkg::state_e state_q, state_d;
  logic            done_q, done_d;
  logic            hit_q, hit_d;

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bct_pkg::ST_CLEAR;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bct_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = bct_pkg::ST_IDLE;
      end
      bct_pkg::ST_IDLE: begin
        if (start) state_d = bct_pkg::ST_DECODE;
      end
      bct_pkg::ST_DECODE: begin
        case (stat_i.cmd)
          bct_pkg::CMD_WRITE: begin
            state_d = stat_i.wr_ok ? bct_pkg::ST_WR_WRITE : bct_pkg::ST_IDLE;
          end
          bct_pkg::CMD_POINT: begin
            state_d = bct_pkg::ST_DRAIN;
          end
          bct_pkg::CMD_RECT: begin
            if (stat_i.rect_oob || stat_i.rect_empty) state_d = bct_pkg::ST_IDLE;
            else state_d = bct_pkg::ST_RECT;
          end
          bct_pkg::CMD_LINE: begin
            if (stat_i.line_oob || stat_i.line_zero) state_d = bct_pkg::ST_IDLE;
            else state_d = bct_pkg::ST_DIV;
          end
          default: state_d = bct_pkg::ST_IDLE;
        endcase
      end
      bct_pkg::ST_WR_WRITE: begin
        state_d = bct_pkg::ST_IDLE;
      end
      bct_pkg::ST_RECT: begin
        if (stat_i.hit_detect) state_d = bct_pkg::ST_IDLE;
        else if (stat_i.rect_last) state_d = bct_pkg::ST_DRAIN;
      end
      bct_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = bct_pkg::ST_WALK;
      end
      bct_pkg::ST_WALK: begin
        if (stat_i.hit_detect) state_d = bct_pkg::ST_IDLE;
        else if (stat_i.walk_last) state_d = bct_pkg::ST_DRAIN;
      end
      bct_pkg::ST_DRAIN: begin
        state_d = bct_pkg::ST_IDLE;
      end
      default: state_d = bct_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands and the result of a finished item.
  always_comb begin
    cmd_o  = '0;
    done_d = 1'b0;
    hit_d  = 1'b0;
    case (state_q)
      bct_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      bct_pkg::ST_IDLE: begin
        cmd_o.capture = start;
      end
      bct_pkg::ST_DECODE: begin
        case (stat_i.cmd)
          bct_pkg::CMD_WRITE: begin
            if (stat_i.wr_ok) cmd_o.wr_read = 1'b1;
            else done_d = 1'b1;
          end
          bct_pkg::CMD_POINT: begin
            cmd_o.probe_pt = 1'b1;
          end
          bct_pkg::CMD_RECT: begin
            if (stat_i.rect_oob) begin
              done_d = 1'b1;
              hit_d  = 1'b1;
            end else if (stat_i.rect_empty) begin
              done_d = 1'b1;
            end
          end
          bct_pkg::CMD_LINE: begin
            if (stat_i.line_oob) begin
              done_d = 1'b1;
              hit_d  = 1'b1;
            end else if (stat_i.line_zero) begin
              done_d = 1'b1;
            end else begin
              cmd_o.div_init = 1'b1;
            end
          end
          default: done_d = 1'b1;
        endcase
      end
      bct_pkg::ST_WR_WRITE: begin
        cmd_o.wr_write = 1'b1;
        done_d         = 1'b1;
      end
      bct_pkg::ST_RECT: begin
        // A hit seen on an earlier row ends the scan at once.
        if (stat_i.hit_detect) begin
          done_d = 1'b1;
          hit_d  = 1'b1;
        end else begin
          cmd_o.probe_rect = 1'b1;
        end
      end
      bct_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      bct_pkg::ST_WALK: begin
        if (stat_i.hit_detect) begin
          done_d = 1'b1;
          hit_d  = 1'b1;
        end else begin
          cmd_o.probe_line = 1'b1;
        end
      end
      bct_pkg::ST_DRAIN: begin
        // The last probe's answer arrives here.
        done_d = 1'b1;
        hit_d  = stat_i.hit_detect;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy   = (state_q != bct_pkg::ST_IDLE);
  assign done_o = done_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bct_datapath.sv
// Datapath of the bitmap collision tester: command registers, map size
// registers, bounds checks, step divider, line walker, row scanner and bitmap RAM.
// Depends on bct_pkg and bct_ram.
`default_nettype none

module bct_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  cmd_i,
  input  logic signed [bct_pkg::FIELD_W-1:0] first_x_i,
  input  logic signed [bct_pkg::FIELD_W-1:0] first_y_i,
  input  logic signed [bct_pkg::FIELD_W-1:0] second_x_i,
  input  logic signed [bct_pkg::FIELD_W-1:0] second_y_i,
  input  logic                        pixel_bit_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [bct_pkg::CFG_W-1:0]   cfg_data_i,
  input  bct_pkg::ctrl_cmd_t          ctl_i,
  output bct_pkg::ctrl_stat_t         stat_o
);

  localparam int CW    = bct_pkg::CW;
  localparam int PW    = bct_pkg::PW;
  localparam int FRAC  = bct_pkg::FRAC;
  localparam int NW    = bct_pkg::NW;
  localparam int QW    = bct_pkg::QW;
  localparam int DCW   = bct_pkg::DCW;
  localparam int XLW   = bct_pkg::XLW;
  localparam int YW    = bct_pkg::YW;
  localparam int FW    = bct_pkg::FIELD_W;
  localparam int MAXW  = bct_pkg::MAX_WIDTH;
  localparam int MAXH  = bct_pkg::MAX_HEIGHT;

  localparam logic signed [CW-1:0] MAXW_C   = CW'(MAXW);
  localparam logic signed [CW-1:0] MAXH_C   = CW'(MAXH);
  localparam logic signed [PW-1:0] STEP_ONE =
    {{(PW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  // Captured item.
  bct_pkg::cmd_e         cmd_q;
  logic signed [FW-1:0]  fx_q, fy_q, sx_q, sy_q;
  logic                  pix_q;

  // Map size registers.
  logic [bct_pkg::CFG_W-1:0] map_w_q, map_h_q;

  // Sequencing registers.
  logic [YW-1:0]         clr_cnt_q;
  logic signed [CW-1:0]  cur_y_q;
  logic [NW-1:0]         n_q;
  logic [NW:0]           rem_q;
  logic [QW-1:0]         quot_q;
  logic [DCW-1:0]        div_cnt_q;
  logic                  major_x_q, dxneg_q, dyneg_q;
  logic signed [PW-1:0]  px_q, py_q;
  logic [NW-1:0]         step_cnt_q;

  // Probe stage, aligned with the RAM read data.
  logic                  probe_valid_q;
  logic                  probe_oob_q;
  logic [XLW-1:0]        probe_lo_q, probe_hi_q;

  // Combinational values.
  logic signed [CW-1:0]  eff_w, eff_h, cfg_w_ext, cfg_h_ext;
  logic signed [CW-1:0]  x1, y1, x2, y2;
  logic signed [CW-1:0]  rect_right, rect_bottom;
  logic signed [CW-1:0]  dx, dy, adx, ady, n_full, a_full;
  logic                  major_x, wr_ok;
  logic [NW:0]           div_t, div_n;
  logic                  div_ge;
  logic signed [PW-1:0]  quot_ext, mag_x, mag_y, step_x, step_y;
  logic signed [CW-1:0]  ix, iy;
  logic                  line_s_oob;
  logic [MAXW-1:0]       mask, ram_rdata, merged, ram_wdata;
  logic                  ram_en, ram_we;
  logic [YW-1:0]         ram_addr;
  logic                  hit_detect;

  // Effective map size: the register, limited to what the RAM holds.
  assign cfg_w_ext = CW'(map_w_q);
  assign cfg_h_ext = CW'(map_h_q);
  assign eff_w = (cfg_w_ext < MAXW_C) ? cfg_w_ext : MAXW_C;
  assign eff_h = (cfg_h_ext < MAXH_C) ? cfg_h_ext : MAXH_C;

  // Sign-extended coordinates of the captured item.
  assign x1 = {{(CW-FW){fx_q[FW-1]}}, fx_q};
  assign y1 = {{(CW-FW){fy_q[FW-1]}}, fy_q};
  assign x2 = {{(CW-FW){sx_q[FW-1]}}, sx_q};
  assign y2 = {{(CW-FW){sy_q[FW-1]}}, sy_q};

  // Point and write bounds.
  assign wr_ok = (x1 >= 0) && (y1 >= 0) && (x1 < eff_w) && (y1 < eff_h);

  // Rectangle extents.
  assign rect_right  = x1 + x2;
  assign rect_bottom = y1 + y2;

  // Line deltas: the longer axis sets the step count.
  assign dx      = x2 - x1;
  assign dy      = y2 - y1;
  assign adx     = (dx < 0) ? -dx : dx;
  assign ady     = (dy < 0) ? -dy : dy;
  assign major_x = (adx >= ady);
  assign n_full  = major_x ? adx : ady;
  assign a_full  = major_x ? ady : adx;

  // Restoring divider step for the minor-axis step: (a << FRAC) / n.
  // The first iteration tests a against n unshifted, since a may equal n.
  assign div_n  = {1'b0, n_q};
  assign div_t  = (div_cnt_q == '0) ? rem_q : {rem_q[NW-1:0], 1'b0};
  assign div_ge = (div_t >= div_n);

  // Per-step increments: one pixel on the major axis, the quotient on the other.
  assign quot_ext = {{(PW-QW){1'b0}}, quot_q};
  assign mag_x    = major_x_q ? STEP_ONE : quot_ext;
  assign mag_y    = major_x_q ? quot_ext : STEP_ONE;
  assign step_x   = dxneg_q ? -mag_x : mag_x;
  assign step_y   = dyneg_q ? -mag_y : mag_y;

  // Integer part of the current walk position.
  assign ix = px_q[PW-1:FRAC];
  assign iy = py_q[PW-1:FRAC];
  assign line_s_oob = (ix < 0) || (iy < 0) || (ix >= eff_w) || (iy >= eff_h);

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= bct_pkg::CFG_W'(256);
      map_h_q <= bct_pkg::CFG_W'(256);
    end else if (cfg_valid_i) begin
      case (bct_pkg::cfg_idx_e'(cfg_index_i))
        bct_pkg::CFG_MAP_WIDTH:  map_w_q <= cfg_data_i;
        bct_pkg::CFG_MAP_HEIGHT: map_h_q <= cfg_data_i;
        default:                 map_w_q <= map_w_q;
      endcase
    end
  end

  // Clear sweep counter and probe valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q     <= '0;
      probe_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr_step) clr_cnt_q <= clr_cnt_q + YW'(1);
      probe_valid_q <= ctl_i.probe_pt | ctl_i.probe_rect | ctl_i.probe_line;
    end
  end

  // Item capture, row scan, divider and walker registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= bct_pkg::cmd_e'(cmd_i);
      fx_q    <= first_x_i;
      fy_q    <= first_y_i;
      sx_q    <= second_x_i;
      sy_q    <= second_y_i;
      pix_q   <= pixel_bit_i;
      cur_y_q <= {{(CW-FW){first_y_i[FW-1]}}, first_y_i};
    end else if (ctl_i.probe_rect) begin
      cur_y_q <= cur_y_q + CW'(1);
    end

    if (ctl_i.div_init) begin
      n_q        <= n_full[NW-1:0];
      rem_q      <= {1'b0, a_full[NW-1:0]};
      quot_q     <= '0;
      div_cnt_q  <= '0;
      major_x_q  <= major_x;
      dxneg_q    <= (dx < 0);
      dyneg_q    <= (dy < 0);
      px_q       <= {x1, {FRAC{1'b0}}};
      py_q       <= {y1, {FRAC{1'b0}}};
      step_cnt_q <= '0;
    end else if (ctl_i.div_step) begin
      rem_q     <= div_ge ? (div_t - div_n) : div_t;
      quot_q    <= {quot_q[QW-2:0], div_ge};
      div_cnt_q <= div_cnt_q + DCW'(1);
    end else if (ctl_i.probe_line) begin
      px_q       <= px_q + step_x;
      py_q       <= py_q + step_y;
      step_cnt_q <= step_cnt_q + NW'(1);
    end
  end

  // Probe stage: which columns of the row are tested, or a forced hit.
  always_ff @(posedge clk_i) begin
    if (ctl_i.probe_pt) begin
      probe_oob_q <= !wr_ok;
      probe_lo_q  <= fx_q[XLW-1:0];
      probe_hi_q  <= fx_q[XLW-1:0] + XLW'(1);
    end else if (ctl_i.probe_rect) begin
      probe_oob_q <= 1'b0;
      probe_lo_q  <= x1[XLW-1:0];
      probe_hi_q  <= rect_right[XLW-1:0];
    end else if (ctl_i.probe_line) begin
      probe_oob_q <= line_s_oob;
      probe_lo_q  <= ix[XLW-1:0];
      probe_hi_q  <= ix[XLW-1:0] + XLW'(1);
    end
  end

  // Column mask of the probed span, and the row merge for a pixel write.
  always_comb begin
    for (int i = 0; i < MAXW; i++) begin
      mask[i]   = (XLW'(i) >= probe_lo_q) && (XLW'(i) < probe_hi_q);
      merged[i] = (XLW'(i) == fx_q[XLW-1:0]) ? pix_q : ram_rdata[i];
    end
  end

  assign hit_detect = probe_valid_q && (probe_oob_q || (|(ram_rdata & mask)));

  // RAM port: one row per access.
  assign ram_we = ctl_i.clr_step | ctl_i.wr_write;
  assign ram_en = ram_we | ctl_i.wr_read | ctl_i.probe_pt |
                  ctl_i.probe_rect | ctl_i.probe_line;
  assign ram_wdata = ctl_i.clr_step ? '0 : merged;

  always_comb begin
    if (ctl_i.clr_step) begin
      ram_addr = clr_cnt_q;
    end else if (ctl_i.probe_rect) begin
      ram_addr = cur_y_q[YW-1:0];
    end else if (ctl_i.probe_line) begin
      ram_addr = iy[YW-1:0];
    end else begin
      ram_addr = fy_q[YW-1:0];
    end
  end

  bct_ram #(
    .WIDTH (MAXW),
    .DEPTH (MAXH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Status to the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd_q;
    stat_o.clr_last   = (clr_cnt_q == YW'(MAXH - 1));
    stat_o.wr_ok      = wr_ok;
    stat_o.rect_oob   = (x1 < 0) || (y1 < 0) || (rect_right > eff_w) ||
                        (rect_bottom > eff_h);
    stat_o.rect_empty = (x2 <= 0) || (y2 <= 0);
    stat_o.line_oob   = (x1 < 0) || (y1 < 0) || (x2 < 0) || (y2 < 0) ||
                        (x1 > eff_w) || (x2 > eff_w) || (y1 > eff_h) || (y2 > eff_h);
    stat_o.line_zero  = (n_full == 0);
    stat_o.rect_last  = (cur_y_q == (rect_bottom - CW'(1)));
    stat_o.div_last   = (div_cnt_q == DCW'(QW - 1));
    stat_o.walk_last  = (step_cnt_q == (n_q - NW'(1)));
    stat_o.hit_detect = hit_detect;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_collision_tester.sv
// Top level of the bitmap collision tester: controller plus datapath.
// Depends on bct_pkg, bct_ctrl, bct_datapath and bct_ram.
//
// Usage:
//   Commands enter on start/busy: an item transfers at a rising edge with start
//   high and busy low. cmd_i selects write pixel, test point, test rectangle or
//   test line; first/second coordinates and pixel_bit_i go with it.
//   Each item returns exactly one result: hit_o is valid for the single cycle
//   in which done_o is high. The receiver cannot stall; a new item may be
//   started in the cycle that done_o is shown.
//   Map size registers transfer on cfg_valid_i/cfg_ready_o (ready is always
//   high): index 0 is the width, index 1 the height. Write them while idle.
// Sequence after the accepting edge:
//   a write reads its row in decode, then writes it back (outside the map it
//   ends after decode); a point reads its row; a rectangle or line that is
//   out of bounds, empty or of zero length ends after decode; a rectangle
//   reads its rows, a line runs 17 divider iterations, then one row per step.
//   Hits end a scan early; the one-row-per-cycle RAM port paces both scans.
// Reset: asynchronous, active low. After reset the bitmap is cleared one row
//   per cycle, all MAX_HEIGHT (256) rows, with busy high; config writes are
//   taken meanwhile.
`default_nettype none

module bitmap_collision_tester (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd_i,
  input  logic signed [bct_pkg::FIELD_W-1:0]  first_x_i,
  input  logic signed [bct_pkg::FIELD_W-1:0]  first_y_i,
  input  logic signed [bct_pkg::FIELD_W-1:0]  second_x_i,
  input  logic signed [bct_pkg::FIELD_W-1:0]  second_y_i,
  input  logic                                pixel_bit_i,
  output logic                                done_o,
  output logic                                hit_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [bct_pkg::CFG_W-1:0]           cfg_data_i
);

  bct_pkg::ctrl_cmd_t  ctl_cmd;
  bct_pkg::ctrl_stat_t ctl_stat;

  // Sequencing of each command.
  bct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (ctl_stat),
    .cmd_o  (ctl_cmd),
    .done_o (done_o),
    .hit_o  (hit_o)
  );

  // Registers, arithmetic and the bitmap.
  bct_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .pixel_bit_i (pixel_bit_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl_cmd),
    .stat_o      (ctl_stat)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bct_checker.sv
// Port-level assertions for the bitmap collision tester, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module bct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // A result is only shown once the block is ready for the next command.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Results never come in consecutive cycles: every item needs a decode cycle.
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results in back-to-back cycles");

  // An idle block with no new command produces no result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !done_o)
    else $error("result without a command");

endmodule

bind bitmap_collision_tester bct_checker u_bct_checker (.*);

`default_nettype wire
